// ----- rtl/prf_pkg.sv -----
package prf_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int IDX_W       = $clog2(PAL_ENTRIES);
  localparam int LVL_W       = 8;
  localparam int FIX_W       = 18;
  localparam int NUM_CH      = 3;
  localparam int ENTRY_W     = NUM_CH * FIX_W;
  localparam int CNT_W       = 5;
  localparam int PROD_W      = 14;
  localparam int SCALE_W     = LVL_W + FIX_W;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_RAMP_A = 2'd1,
    OP_RAMP_B = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  localparam logic [IDX_W-1:0]   RAMP_A_BASE = 8'h40;
  localparam logic [IDX_W-1:0]   RAMP_B_BASE = 8'hB0;
  localparam logic [CNT_W-1:0]   RAMP_A_LAST = 5'd31;
  localparam logic [CNT_W-1:0]   RAMP_B_LAST = 5'd6;
  localparam logic [LVL_W-1:0]   LVL_MAX     = 8'h3F;
  // (c << 16) / 100: c * 41943 / 64, then one correction step
  localparam logic [15:0]        FIX_RECIP   = 16'd41943;
  localparam logic [6:0]         FIX_DIV     = 7'd100;
  // w / 5 for w < 1024, w / 21 for w < 13000
  localparam logic [7:0]         DIV5_RECIP  = 8'd205;
  localparam logic [12:0]        DIV21_RECIP = 13'd6242;
  localparam logic [SCALE_W-1:0] ROUND_HALF  = 26'h8000;

  typedef struct packed {
    logic capture;
    logic cnt_clr;
    logic cnt_inc;
    op_t  op;
    logic prod_en;
    logic lvl_en;
    logic fix_en;
    logic wr_en;
    logic rd_en;
    logic out_en;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

endpackage

// ----- rtl/prf_ram.sv -----
module prf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/prf_ctrl.sv -----
module prf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  prf_pkg::op_t       in_op,
  input  prf_pkg::dp_stat_t  stat,
  output logic               busy,
  output prf_pkg::dp_cmd_t   cmd
);

  import prf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD,
    ST_OUT,
    ST_PROD,
    ST_LVL,
    ST_FIX,
    ST_WR
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   busy_r, busy_nxt;
  logic   accept;

  assign accept = start & ~busy_r;
  assign busy   = busy_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;

    case (state_r)
      ST_IDLE: begin
        state_nxt = ST_IDLE;
      end
      ST_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        cmd.out_en = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_PROD: begin
        cmd.prod_en = 1'b1;
        state_nxt   = ST_LVL;
      end
      ST_LVL: begin
        cmd.lvl_en = 1'b1;
        state_nxt  = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix_en = 1'b1;
        state_nxt  = ST_WR;
      end
      ST_WR: begin
        cmd.wr_en = 1'b1;
        if (op_r == OP_LOAD || stat.last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.cnt_inc = 1'b1;
          state_nxt   = ST_PROD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (accept) begin
      cmd.capture = 1'b1;
      cmd.cnt_clr = 1'b1;
      op_nxt      = in_op;
      case (in_op)
        OP_LOAD:   state_nxt = ST_LVL;
        OP_RAMP_A: state_nxt = ST_PROD;
        OP_RAMP_B: state_nxt = ST_PROD;
        OP_READ:   state_nxt = ST_RD;
        default:   state_nxt = ST_IDLE;
      endcase
    end

    busy_nxt = !(state_nxt == ST_IDLE || state_nxt == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_LOAD;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

// ----- rtl/prf_dp.sv -----
module prf_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  prf_pkg::dp_cmd_t           cmd,
  output prf_pkg::dp_stat_t          stat,
  input  logic [prf_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [prf_pkg::LVL_W-1:0]  in_red_in,
  input  logic [prf_pkg::LVL_W-1:0]  in_green_in,
  input  logic [prf_pkg::LVL_W-1:0]  in_blue_in,
  input  logic [prf_pkg::LVL_W-1:0]  in_intensity,
  output logic                       out_valid,
  output logic [prf_pkg::IDX_W-1:0]  out_entry_out,
  output logic [prf_pkg::LVL_W-1:0]  out_red_out,
  output logic [prf_pkg::LVL_W-1:0]  out_green_out,
  output logic [prf_pkg::LVL_W-1:0]  out_blue_out
);

  import prf_pkg::*;

  logic [IDX_W-1:0]   idx_r;
  logic [LVL_W-1:0]   inten_r;
  logic [LVL_W-1:0]   base_r  [NUM_CH];
  logic [CNT_W-1:0]   cnt_r;
  logic [PROD_W-1:0]  prod_r  [NUM_CH];
  logic [PROD_W-1:0]  prod_nxt[NUM_CH];
  logic [LVL_W-1:0]   lvl_r   [NUM_CH];
  logic [LVL_W-1:0]   lvl_nxt [NUM_CH];
  logic [FIX_W-1:0]   q0_r    [NUM_CH];
  logic [FIX_W-1:0]   q0_nxt  [NUM_CH];
  logic [FIX_W-1:0]   fix_val [NUM_CH];
  logic [LVL_W-1:0]   scaled  [NUM_CH];

  logic [5:0]         fsat    [NUM_CH];
  logic [7:0]         coef_a;
  logic [5:0]         coef_b;
  logic [16:0]        div5_p  [NUM_CH];
  logic [25:0]        div21_p [NUM_CH];
  logic [8:0]         div21_q [NUM_CH];
  logic [23:0]        fix_p   [NUM_CH];
  logic [23:0]        fix_rem [NUM_CH];
  logic [SCALE_W-1:0] scale_p [NUM_CH];
  logic [FIX_W-1:0]   stored  [NUM_CH];

  logic               valid_r [PAL_ENTRIES];
  logic               valid_rd_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_entry_r;
  logic [LVL_W-1:0]   out_ch_r [NUM_CH];

  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic [ENTRY_W-1:0] rdata;

  assign stat.last = (cmd.op == OP_RAMP_A) ? (cnt_r == RAMP_A_LAST) : (cnt_r == RAMP_B_LAST);

  assign coef_a = 8'd16 + ({4'd0, cnt_r[3:0]} * 8'd9);
  assign coef_b = 6'd7 + ({3'd0, cnt_r[2:0]} * 6'd6);

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      fsat[c] = (base_r[c] > LVL_MAX) ? LVL_MAX[5:0] : base_r[c][5:0];

      case (cmd.op)
        OP_RAMP_A: begin
          if (cnt_r[4]) begin
            prod_nxt[c] = PROD_W'(cnt_r[3:0]) * PROD_W'(6'd63 - fsat[c])
                        + PROD_W'({fsat[c], 4'b0000});
          end else begin
            prod_nxt[c] = PROD_W'(fsat[c]) * PROD_W'(coef_a);
          end
        end
        OP_RAMP_B: prod_nxt[c] = PROD_W'(base_r[c]) * PROD_W'(coef_b);
        default:   prod_nxt[c] = '0;
      endcase

      div5_p[c]  = 17'(prod_r[c][13:5]) * 17'(DIV5_RECIP);
      div21_p[c] = 26'(prod_r[c][13:1]) * 26'(DIV21_RECIP);
      div21_q[c] = div21_p[c][25:17];

      case (cmd.op)
        OP_RAMP_A: begin
          if (cnt_r[4]) begin
            lvl_nxt[c] = prod_r[c][11:4];
          end else begin
            lvl_nxt[c] = {1'b0, div5_p[c][16:10]};
          end
        end
        OP_RAMP_B: begin
          lvl_nxt[c] = (div21_q[c] > 9'(LVL_MAX)) ? LVL_MAX : div21_q[c][7:0];
        end
        default:   lvl_nxt[c] = base_r[c];
      endcase

      fix_p[c]   = 24'(lvl_r[c]) * 24'(FIX_RECIP);
      q0_nxt[c]  = fix_p[c][23:6];
      fix_rem[c] = {lvl_r[c], 16'd0} - (24'(q0_r[c]) * 24'(FIX_DIV));
      fix_val[c] = q0_r[c] + FIX_W'(fix_rem[c] >= 24'(FIX_DIV));

      stored[c]  = valid_rd_r ? rdata[(NUM_CH-1-c)*FIX_W +: FIX_W] : '0;
      scale_p[c] = SCALE_W'(inten_r) * SCALE_W'(stored[c]) + ROUND_HALF;
      scaled[c]  = scale_p[c][23:16];
    end
  end

  always_comb begin
    case (cmd.op)
      OP_RAMP_A: waddr = RAMP_A_BASE + IDX_W'(cnt_r);
      OP_RAMP_B: waddr = RAMP_B_BASE + IDX_W'(cnt_r);
      default:   waddr = idx_r;
    endcase
  end

  assign wdata = {fix_val[0], fix_val[1], fix_val[2]};

  prf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAL_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (idx_r),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r     <= in_entry_index;
      inten_r   <= in_intensity;
      base_r[0] <= in_red_in;
      base_r[1] <= in_green_in;
      base_r[2] <= in_blue_in;
    end
    for (int c = 0; c < NUM_CH; c++) begin
      if (cmd.prod_en) begin
        prod_r[c] <= prod_nxt[c];
      end
      if (cmd.lvl_en) begin
        lvl_r[c] <= lvl_nxt[c];
      end
      if (cmd.fix_en) begin
        q0_r[c] <= q0_nxt[c];
      end
      if (cmd.out_en) begin
        out_ch_r[c] <= scaled[c];
      end
    end
    if (cmd.rd_en) begin
      valid_rd_r <= valid_r[idx_r];
    end
    if (cmd.out_en) begin
      out_entry_r <= idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < PAL_ENTRIES; k++) begin
        valid_r[k] <= 1'b0;
      end
    end else begin
      out_valid_r <= cmd.out_en;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.wr_en) begin
        valid_r[waddr] <= 1'b1;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_entry_out = out_entry_r;
  assign out_red_out   = out_ch_r[0];
  assign out_green_out = out_ch_r[1];
  assign out_blue_out  = out_ch_r[2];

endmodule

// ----- rtl/palette_ramp_and_fade_core.sv -----
// 256-entry RGB palette with ramp generation and intensity-scaled readout.
// A request is taken on a clock edge with start high and busy low. A read
// returns one result, after a palette memory read and a scaling multiply,
// shown for exactly one cycle with out_valid high; out_valid is never held
// off, so the receiver must take each result in that cycle. A new read can
// be taken while the previous read is in its scaling multiply. A load
// passes through level, fixed-point and write steps, ramp A through 32
// entries and ramp B through 7 entries; each ramp entry passes through
// product, level, fixed-point and write steps of the shared datapath. Writes
// produce no result. The palette reads as zero after reset with no clearing
// pass: per-entry valid bits mask unwritten entries.
module palette_ramp_and_fade_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 in_opcode,
  input  logic [prf_pkg::IDX_W-1:0]  in_entry_index,
  input  logic [prf_pkg::LVL_W-1:0]  in_red_in,
  input  logic [prf_pkg::LVL_W-1:0]  in_green_in,
  input  logic [prf_pkg::LVL_W-1:0]  in_blue_in,
  input  logic [prf_pkg::LVL_W-1:0]  in_intensity,
  output logic                       out_valid,
  output logic [prf_pkg::IDX_W-1:0]  out_entry_out,
  output logic [prf_pkg::LVL_W-1:0]  out_red_out,
  output logic [prf_pkg::LVL_W-1:0]  out_green_out,
  output logic [prf_pkg::LVL_W-1:0]  out_blue_out
);

  import prf_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  op_t      in_op;

  assign in_op = op_t'(in_opcode);

  prf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  prf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_entry_index (in_entry_index),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .in_intensity   (in_intensity),
    .out_valid      (out_valid),
    .out_entry_out  (out_entry_out),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out)
  );

endmodule

// ----- rtl/prf_chk.sv -----
module prf_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 in_opcode,
  input logic [prf_pkg::IDX_W-1:0]  in_entry_index,
  input logic                       out_valid,
  input logic [prf_pkg::IDX_W-1:0]  out_entry_out
);

  import prf_pkg::*;

  logic rd_req;
  logic wr_req;

  assign rd_req = start && !busy && (in_opcode == OP_READ);
  assign wr_req = start && !busy && (in_opcode != OP_READ);

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !busy))
    else $error("outputs active after reset");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req |-> ##3 (out_valid && out_entry_out == $past(in_entry_index, 3)))
    else $error("read request without matching result");

  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req |-> ##2 !out_valid)
    else $error("write request produced a result");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

endmodule

bind palette_ramp_and_fade_core prf_chk u_prf_chk (.*);
